// ===== rtl/core/pwlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear wavelength correction package
// Shared widths, codes, transaction types and sequencer states.
// ----------------------------------------------------------------------------
package pwlc_pkg;

	localparam int MaxPoints = 8;
	localparam int IdxW      = 3;
	localparam int CntW      = 4;
	localparam int WlW       = 24;
	localparam int OfsW      = 16;
	localparam int ProdW     = 40;
	localparam int DivCntW   = 6;

	typedef enum logic {
		MODE_QUERY = 1'b0,
		MODE_LOAD  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_RANGE  = 2'd1,
		STATUS_LOADED = 2'd2
	} status_t;

	typedef struct packed {
		mode_t                   mode;
		logic [IdxW-1:0]         point_index;
		logic [WlW-1:0]          wavelength;
		logic signed [OfsW-1:0]  point_offset;
	} req_t;

	typedef struct packed {
		logic [WlW-1:0] corrected_wavelength;
		status_t        status;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_SCAN,
		ST_Y0,
		ST_Y1,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/piecewise_linear_wavelength_correction.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear wavelength correction
// Calibration table with segment search, one shared restoring divider and
// a saturating correction of the query wavelength.
// ----------------------------------------------------------------------------
//  channel   direction   handshake              payload
//  req       in          req_valid, req_stall   pwlc_pkg::req_t
//  rsp       out         rsp_valid, rsp_stall   pwlc_pkg::rsp_t
//  cfg       in          cfg_we                 cfg_wdata (points in use)
//
// A load transaction goes straight to the output stage; an out-of-range query
// ends at the low or the high bound check. A corrected query does 1 to 7 table
// reads in the segment search, then runs the bit-serial divider. A query on a
// zero-width segment skips the divider.
// One transaction is in work at a time; req_stall is high until it has moved
// into the output register, which may still hold the previous result.
// Reset clears the control state and sets points in use to 8; the table
// holds no defined value until it is loaded.
module piecewise_linear_wavelength_correction (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pwlc_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pwlc_pkg::rsp_t                   rsp,
	input  logic                             cfg_we,
	input  logic [pwlc_pkg::CntW-1:0]        cfg_wdata
);

	pwlc_pkg::state_t state_q, state_d;

	logic [pwlc_pkg::CntW-1:0]         piu_q;
	logic [pwlc_pkg::WlW-1:0]          wl_tab_q  [pwlc_pkg::MaxPoints];
	logic signed [pwlc_pkg::OfsW-1:0]  ofs_tab_q [pwlc_pkg::MaxPoints];

	logic [pwlc_pkg::IdxW-1:0]         idx_q;
	logic [pwlc_pkg::IdxW-1:0]         n_last_q;
	logic [pwlc_pkg::WlW-1:0]          w_q;
	logic [pwlc_pkg::WlW-1:0]          xa_q;
	logic [pwlc_pkg::WlW-1:0]          xb_q;
	logic signed [pwlc_pkg::OfsW-1:0]  y0_q;
	logic signed [pwlc_pkg::WlW:0]     dx_q;
	logic signed [pwlc_pkg::OfsW:0]    dy_q;
	logic [pwlc_pkg::WlW-1:0]          span_mag_q;
	logic                              span_neg_q;
	logic signed [pwlc_pkg::WlW+1:0]   wy_q;
	logic                              neg_q;
	logic [pwlc_pkg::ProdW-1:0]        quo_q;
	logic [pwlc_pkg::WlW-1:0]          rem_q;
	logic [pwlc_pkg::DivCntW-1:0]      cnt_q;
	logic [pwlc_pkg::WlW-1:0]          res_q;
	pwlc_pkg::status_t                 status_q;
	logic                              rsp_valid_q;
	pwlc_pkg::rsp_t                    rsp_q;

	logic                              req_acc;
	logic                              out_free;
	logic                              out_load;
	logic [pwlc_pkg::CntW-1:0]         n_used;
	logic [pwlc_pkg::WlW-1:0]          rd_wl;
	logic signed [pwlc_pkg::OfsW-1:0]  rd_ofs;
	logic                              hit;
	logic signed [pwlc_pkg::WlW:0]     span;
	logic signed [41:0]                prod;
	logic [41:0]                       prod_abs;
	logic [pwlc_pkg::WlW:0]            r_try;
	logic [pwlc_pkg::WlW:0]            r_diff;
	logic signed [pwlc_pkg::ProdW:0]   q_signed;
	logic signed [41:0]                res_full;

	// Table read port and clamped point count.
	always_comb begin
		rd_wl  = wl_tab_q[idx_q];
		rd_ofs = ofs_tab_q[idx_q];
		if (piu_q < pwlc_pkg::CntW'(2)) begin
			n_used = pwlc_pkg::CntW'(2);
		end else if (piu_q > pwlc_pkg::CntW'(pwlc_pkg::MaxPoints)) begin
			n_used = pwlc_pkg::CntW'(pwlc_pkg::MaxPoints);
		end else begin
			n_used = piu_q;
		end
	end

	// Datapath arithmetic shared by the sequencer states.
	always_comb begin
		hit      = ((w_q >= xa_q) && (w_q < rd_wl)) || (idx_q == n_last_q);
		span     = $signed({1'b0, xb_q}) - $signed({1'b0, xa_q});
		prod     = 42'(dx_q) * 42'(dy_q);
		prod_abs = prod[41] ? 42'(-prod) : prod;
		r_try    = {rem_q, quo_q[pwlc_pkg::ProdW-1]};
		r_diff   = r_try - {1'b0, span_mag_q};
		q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		res_full = 42'(wy_q) - 42'(q_signed);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pwlc_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d = (req.mode == pwlc_pkg::MODE_LOAD) ? pwlc_pkg::ST_DONE
						: pwlc_pkg::ST_LO;
				end
			end
			pwlc_pkg::ST_LO: begin
				state_d = (w_q < rd_wl) ? pwlc_pkg::ST_DONE : pwlc_pkg::ST_HI;
			end
			pwlc_pkg::ST_HI: begin
				state_d = (w_q > rd_wl) ? pwlc_pkg::ST_DONE : pwlc_pkg::ST_SCAN;
			end
			pwlc_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = pwlc_pkg::ST_Y0;
				end
			end
			pwlc_pkg::ST_Y0: begin
				state_d = pwlc_pkg::ST_Y1;
			end
			pwlc_pkg::ST_Y1: begin
				state_d = pwlc_pkg::ST_MUL;
			end
			pwlc_pkg::ST_MUL: begin
				state_d = (span_mag_q == '0) ? pwlc_pkg::ST_FIN : pwlc_pkg::ST_DIV;
			end
			pwlc_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = pwlc_pkg::ST_FIN;
				end
			end
			pwlc_pkg::ST_FIN: begin
				state_d = pwlc_pkg::ST_DONE;
			end
			pwlc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pwlc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pwlc_pkg::ST_IDLE;
			end
		endcase
	end

	// Handshake outputs.
	always_comb begin
		req_stall = (state_q != pwlc_pkg::ST_IDLE);
		req_acc   = req_valid && !req_stall;
		out_free  = !rsp_valid_q || !rsp_stall;
		out_load  = (state_q == pwlc_pkg::ST_DONE) && out_free;
		rsp_valid = rsp_valid_q;
		rsp       = rsp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwlc_pkg::ST_IDLE;
			piu_q       <= pwlc_pkg::CntW'(pwlc_pkg::MaxPoints);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				piu_q <= cfg_wdata;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.corrected_wavelength <= res_q;
			rsp_q.status               <= status_q;
		end
		case (state_q)
			pwlc_pkg::ST_IDLE: begin
				if (req_acc) begin
					w_q      <= req.wavelength;
					idx_q    <= '0;
					n_last_q <= pwlc_pkg::IdxW'(n_used - pwlc_pkg::CntW'(1));
					res_q    <= '0;
					if (req.mode == pwlc_pkg::MODE_LOAD) begin
						wl_tab_q[req.point_index]  <= req.wavelength;
						ofs_tab_q[req.point_index] <= req.point_offset;
						status_q                   <= pwlc_pkg::STATUS_LOADED;
					end else begin
						status_q <= pwlc_pkg::STATUS_RANGE;
					end
				end
			end
			pwlc_pkg::ST_LO: begin
				xa_q  <= rd_wl;
				idx_q <= n_last_q;
			end
			pwlc_pkg::ST_HI: begin
				idx_q <= pwlc_pkg::IdxW'(1);
			end
			pwlc_pkg::ST_SCAN: begin
				if (hit) begin
					xb_q  <= rd_wl;
					idx_q <= idx_q - pwlc_pkg::IdxW'(1);
				end else begin
					xa_q  <= rd_wl;
					idx_q <= idx_q + pwlc_pkg::IdxW'(1);
				end
			end
			pwlc_pkg::ST_Y0: begin
				y0_q  <= rd_ofs;
				idx_q <= idx_q + pwlc_pkg::IdxW'(1);
			end
			pwlc_pkg::ST_Y1: begin
				dx_q       <= $signed({1'b0, w_q}) - $signed({1'b0, xa_q});
				dy_q       <= 17'(rd_ofs) - 17'(y0_q);
				span_neg_q <= span[pwlc_pkg::WlW];
				span_mag_q <= span[pwlc_pkg::WlW] ? pwlc_pkg::WlW'(-span)
					: span[pwlc_pkg::WlW-1:0];
				wy_q       <= $signed({2'b00, w_q}) - 26'(y0_q);
			end
			pwlc_pkg::ST_MUL: begin
				neg_q <= prod[41] ^ span_neg_q;
				rem_q <= '0;
				cnt_q <= pwlc_pkg::DivCntW'(pwlc_pkg::ProdW - 1);
				quo_q <= (span_mag_q == '0) ? '0 : prod_abs[pwlc_pkg::ProdW-1:0];
			end
			pwlc_pkg::ST_DIV: begin
				cnt_q <= cnt_q - pwlc_pkg::DivCntW'(1);
				if (!r_diff[pwlc_pkg::WlW]) begin
					rem_q <= r_diff[pwlc_pkg::WlW-1:0];
					quo_q <= {quo_q[pwlc_pkg::ProdW-2:0], 1'b1};
				end else begin
					rem_q <= r_try[pwlc_pkg::WlW-1:0];
					quo_q <= {quo_q[pwlc_pkg::ProdW-2:0], 1'b0};
				end
			end
			pwlc_pkg::ST_FIN: begin
				status_q <= pwlc_pkg::STATUS_OK;
				if (res_full[41]) begin
					res_q <= '0;
				end else if (res_full[41:pwlc_pkg::WlW] != '0) begin
					res_q <= '1;
				end else begin
					res_q <= res_full[pwlc_pkg::WlW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
